[hw/rtl/bmbd_pkg.sv]
`default_nettype none

package bmbd_pkg;

    // Work RAM geometry
    localparam int BANK_BYTES = 4096;
    localparam int RAM_BANKS  = 8;
    localparam int BANK_AW    = $clog2(BANK_BYTES);
    localparam int BANK_W     = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int WRAM_DEPTH = BANK_BYTES * RAM_BANKS;
    localparam int WRAM_AW    = $clog2(WRAM_DEPTH);

    // High RAM and I/O byte stores
    localparam int PAGE_DEPTH = 128;
    localparam int PAGE_AW    = $clog2(PAGE_DEPTH);

    // Route codes
    localparam logic [2:0] ROUTE_INTERNAL = 3'd0;
    localparam logic [2:0] ROUTE_CART     = 3'd1;
    localparam logic [2:0] ROUTE_VRAM     = 3'd2;
    localparam logic [2:0] ROUTE_OAM      = 3'd3;
    localparam logic [2:0] ROUTE_VBANK    = 3'd4;

    // Address regions
    localparam logic [2:0] REGION_CART     = 3'd0;
    localparam logic [2:0] REGION_VRAM     = 3'd1;
    localparam logic [2:0] REGION_WRAM     = 3'd2;
    localparam logic [2:0] REGION_OAM      = 3'd3;
    localparam logic [2:0] REGION_UNUSABLE = 3'd4;
    localparam logic [2:0] REGION_IO       = 3'd5;
    localparam logic [2:0] REGION_HRAM     = 3'd6;
    localparam logic [2:0] REGION_IE       = 3'd7;

    // Address map
    localparam logic [15:0] ADDR_VRAM        = 16'h8000;
    localparam logic [15:0] ADDR_EXT_RAM     = 16'hA000;
    localparam logic [15:0] ADDR_WRAM        = 16'hC000;
    localparam logic [15:0] ADDR_WRAM_BANKED = 16'hD000;
    localparam logic [15:0] ADDR_ECHO        = 16'hE000;
    localparam logic [15:0] ADDR_OAM         = 16'hFE00;
    localparam logic [15:0] ADDR_UNUSABLE    = 16'hFEA0;
    localparam logic [15:0] ADDR_IO          = 16'hFF00;
    localparam logic [15:0] ADDR_HRAM        = 16'hFF80;
    localparam logic [15:0] ADDR_IE          = 16'hFFFF;
    localparam logic [15:0] ADDR_VBK         = 16'hFF4F;
    localparam logic [15:0] ADDR_SVBK        = 16'hFF70;
    localparam logic [15:0] ECHO_OFFSET      = 16'h2000;

    // I/O register indexes
    localparam logic [PAGE_AW-1:0] IO_SB = 7'h01;
    localparam logic [PAGE_AW-1:0] IO_SC = 7'h02;
    localparam logic [PAGE_AW-1:0] IO_IF = 7'h0F;

    // Bit masks and fixed values
    localparam logic [7:0] IF_READ_SET   = 8'hE0;
    localparam logic [7:0] IF_WRITE_MASK = 8'h1F;
    localparam logic [7:0] IF_SERIAL     = 8'h08;
    localparam logic [7:0] IF_RESET      = 8'hE1;
    localparam logic [7:0] SC_KEEP       = 8'h7F;
    localparam logic [7:0] UNUSABLE_READ = 8'hFF;
    localparam logic [2:0] SVBK_RESET    = 3'd1;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  route;
        logic [15:0] forward_address;
        logic        serial_valid;
        logic [7:0]  serial_byte;
    } result_t;

    // Boot value of an I/O byte
    function automatic logic [7:0] io_boot(input logic [PAGE_AW-1:0] idx);
        logic [7:0] v;
        case (idx)
            7'h00:   v = 8'hCF;
            7'h02:   v = 8'h7E;
            7'h07:   v = 8'hF8;
            7'h0F:   v = 8'hE1;
            7'h40:   v = 8'h91;
            7'h41:   v = 8'h85;
            7'h47:   v = 8'hFC;
            7'h48:   v = 8'hFF;
            7'h49:   v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Fold echo space down onto work RAM
    function automatic logic [15:0] echo_map(input logic [15:0] a);
        logic [15:0] m;
        m = a;
        if (a >= ADDR_ECHO && a < ADDR_OAM)
            m = a - ECHO_OFFSET;
        return m;
    endfunction

    // Region of an already folded address
    function automatic logic [2:0] addr_region(input logic [15:0] a);
        logic [2:0] r;
        if (a < ADDR_VRAM)
            r = REGION_CART;
        else if (a < ADDR_EXT_RAM)
            r = REGION_VRAM;
        else if (a < ADDR_WRAM)
            r = REGION_CART;
        else if (a < ADDR_ECHO)
            r = REGION_WRAM;
        else if (a < ADDR_UNUSABLE)
            r = REGION_OAM;
        else if (a < ADDR_IO)
            r = REGION_UNUSABLE;
        else if (a < ADDR_HRAM)
            r = REGION_IO;
        else if (a < ADDR_IE)
            r = REGION_HRAM;
        else
            r = REGION_IE;
        return r;
    endfunction

    // Bank in use for the switchable half; zero, or no colour mode, selects bank one
    function automatic logic [BANK_W-1:0] bank_of(input logic [2:0] sel, input logic color);
        logic [2:0] m;
        m = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (sel == 3'(k))
                m = 3'(k % RAM_BANKS);
        end
        if (!color || m == 3'd0)
            m = 3'd1;
        return m[BANK_W-1:0];
    endfunction

    // Work RAM entry of a folded address
    function automatic logic [WRAM_AW-1:0] wram_index(input logic [15:0] a,
                                                      input logic [BANK_W-1:0] bank);
        logic [WRAM_AW-1:0] idx;
        if (a < ADDR_WRAM_BANKED)
            idx = WRAM_AW'(a[BANK_AW-1:0]);
        else
            idx = WRAM_AW'({bank, a[BANK_AW-1:0]});
        return idx;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bmbd_ram.sv]
`default_nettype none

module bmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write through one port, registered read at the same address
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hw/rtl/banked_memory_bus_decoder_top.sv]
`default_nettype none

// Result: the access state registers it into the output register, or into a hold
// register while the output is stalled. A new access is taken only in the idle state,
// after the synchronous read of the work RAM, high RAM and I/O byte memories and the
// write-back of the previous access. Reset: a clearing pass over all 32768 work RAM
// entries (one entry per cycle, high RAM and I/O bytes loaded while the counter is below 128) runs first.
module banked_memory_bus_decoder_top
    import bmbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  read_data,
    output logic      [2:0]  route,
    output logic      [15:0] forward_address,
    output logic             serial_valid,
    output logic      [7:0]  serial_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [WRAM_AW-1:0] clr_cnt_reg;
    logic               color_reg;
    logic [7:0]         if_reg, if_next;
    logic [7:0]         sb_reg, sb_next;
    logic [2:0]         bank_sel_reg, bank_sel_next;
    logic [7:0]         ie_reg, ie_next;
    logic               out_valid_reg;

    logic               op_reg;
    logic [15:0]        addr_reg;
    logic [7:0]         data_reg;
    logic [2:0]         region_reg;
    logic [WRAM_AW-1:0] widx_reg;
    result_t            out_reg, hold_reg, res;

    logic               accept, clearing, in_access, out_free;
    logic [15:0]        in_addr;
    logic [WRAM_AW-1:0] in_widx;

    logic [WRAM_AW-1:0] wram_addr;
    logic               wram_we;
    logic [7:0]         wram_wdata, wram_rdata;
    logic [PAGE_AW-1:0] hram_addr, io_addr;
    logic               hram_we, io_we, io_we_acc;
    logic [7:0]         hram_wdata, hram_rdata, io_wdata, io_wdata_acc, io_rdata;
    logic [PAGE_AW-1:0] reg_idx;
    logic               is_vbk, is_svbk;

    // Handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign clearing  = (state_reg == ST_CLEAR);
    assign in_access = (state_reg == ST_ACCESS);
    assign out_free  = !out_valid_reg || out_ready;

    // Decode the incoming address
    assign in_addr = echo_map(address);
    assign in_widx = wram_index(in_addr, bank_of(bank_sel_reg, color_reg));

    // Memory ports: sweep during clearing, write back in access, else read ahead
    assign wram_addr  = clearing ? clr_cnt_reg : (in_access ? widx_reg : in_widx);
    assign wram_we    = clearing ||
                        (in_access && op_reg == OP_WRITE && region_reg == REGION_WRAM);
    assign wram_wdata = clearing ? 8'h00 : data_reg;

    assign hram_addr  = clearing ? clr_cnt_reg[PAGE_AW-1:0]
                      : (in_access ? addr_reg[PAGE_AW-1:0] : in_addr[PAGE_AW-1:0]);
    assign hram_we    = (clearing && clr_cnt_reg[WRAM_AW-1:PAGE_AW] == '0) ||
                        (in_access && op_reg == OP_WRITE && region_reg == REGION_HRAM);
    assign hram_wdata = clearing ? 8'h00 : data_reg;

    assign io_addr  = hram_addr;
    assign io_we    = (clearing && clr_cnt_reg[WRAM_AW-1:PAGE_AW] == '0) ||
                      (in_access && io_we_acc);
    assign io_wdata = clearing ? io_boot(clr_cnt_reg[PAGE_AW-1:0]) : io_wdata_acc;

    bmbd_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
        .clk   (clk),
        .we    (wram_we),
        .addr  (wram_addr),
        .wdata (wram_wdata),
        .rdata (wram_rdata)
    );

    bmbd_ram #(.WIDTH(8), .DEPTH(PAGE_DEPTH)) u_hram (
        .clk   (clk),
        .we    (hram_we),
        .addr  (hram_addr),
        .wdata (hram_wdata),
        .rdata (hram_rdata)
    );

    bmbd_ram #(.WIDTH(8), .DEPTH(PAGE_DEPTH)) u_io (
        .clk   (clk),
        .we    (io_we),
        .addr  (io_addr),
        .wdata (io_wdata),
        .rdata (io_rdata)
    );

    // Serve the access: read data, route, and register updates
    assign reg_idx = addr_reg[PAGE_AW-1:0];
    assign is_vbk  = (addr_reg == ADDR_VBK) && color_reg;
    assign is_svbk = (addr_reg == ADDR_SVBK) && color_reg;

    always_comb
    begin
        res           = '0;
        io_we_acc     = 1'b0;
        io_wdata_acc  = data_reg;
        if_next       = if_reg;
        sb_next       = sb_reg;
        bank_sel_next = bank_sel_reg;
        ie_next       = ie_reg;
        case (region_reg)
            REGION_CART:
                res.route = ROUTE_CART;
            REGION_VRAM:
                res.route = ROUTE_VRAM;
            REGION_OAM:
                res.route = ROUTE_OAM;
            REGION_WRAM:
            begin
                if (op_reg == OP_READ)
                    res.read_data = wram_rdata;
            end
            REGION_UNUSABLE:
            begin
                if (op_reg == OP_READ)
                    res.read_data = UNUSABLE_READ;
            end
            REGION_HRAM:
            begin
                if (op_reg == OP_READ)
                    res.read_data = hram_rdata;
            end
            REGION_IE:
            begin
                if (op_reg == OP_READ)
                    res.read_data = ie_reg;
                else
                    ie_next = data_reg;
            end
            REGION_IO:
            begin
                if (is_vbk)
                    res.route = ROUTE_VBANK;
                else if (op_reg == OP_READ)
                begin
                    if (reg_idx == IO_IF)
                        res.read_data = IF_READ_SET | if_reg;
                    else if (is_svbk)
                        res.read_data = {5'd0, bank_sel_reg};
                    else if (reg_idx == IO_SB)
                        res.read_data = sb_reg;
                    else
                        res.read_data = io_rdata;
                end
                else if (reg_idx == IO_SC)
                begin
                    io_we_acc = 1'b1;
                    if (data_reg[7])
                    begin
                        io_wdata_acc     = data_reg & SC_KEEP;
                        res.serial_valid = 1'b1;
                        res.serial_byte  = sb_reg;
                        if_next          = if_reg | IF_SERIAL;
                    end
                end
                else if (reg_idx == IO_IF)
                    if_next = data_reg & IF_WRITE_MASK;
                else if (is_svbk)
                    bank_sel_next = data_reg[2:0];
                else if (reg_idx == IO_SB)
                    sb_next = data_reg;
                else
                    io_we_acc = 1'b1;
            end
            default:
                res.route = ROUTE_INTERNAL;
        endcase
        if (res.route != ROUTE_INTERNAL)
            res.forward_address = addr_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == WRAM_AW'(WRAM_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
                state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            color_reg     <= 1'b0;
            if_reg        <= IF_RESET;
            sb_reg        <= 8'h00;
            bank_sel_reg  <= SVBK_RESET;
            ie_reg        <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_valid && cfg_ready)
                color_reg <= cfg_data;
            if (in_access)
            begin
                if_reg       <= if_next;
                sb_reg       <= sb_next;
                bank_sel_reg <= bank_sel_next;
                ie_reg       <= ie_next;
            end
            if ((in_access && out_free) || (state_reg == ST_HOLD && out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: capture the access, then the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            addr_reg   <= in_addr;
            data_reg   <= write_data;
            region_reg <= addr_region(in_addr);
            widx_reg   <= in_widx;
        end
        if (in_access)
        begin
            if (out_free)
                out_reg <= res;
            else
                hold_reg <= res;
        end
        else if (state_reg == ST_HOLD && out_ready)
            out_reg <= hold_reg;
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_reg.read_data;
    assign route           = out_reg.route;
    assign forward_address = out_reg.forward_address;
    assign serial_valid    = out_reg.serial_valid;
    assign serial_byte     = out_reg.serial_byte;

endmodule

`default_nettype wire

[sim/banked_memory_bus_decoder_top_tb.sv]
`timescale 1ns / 1ps

module banked_memory_bus_decoder_top_tb;
    import bmbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PRINT_LIMIT    = 40;

    // Bus map predictor and store of expected bus results
    class bus_scoreboard;
        logic [7:0] wram [WRAM_DEPTH];
        logic [7:0] hram [PAGE_DEPTH];
        logic [7:0] io_regs [PAGE_DEPTH];
        logic [7:0] int_enable;
        logic [2:0] bank_sel;
        logic       color;
        result_t    expected_q[$];
        int         errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        // Load power-on contents, boot values of the I/O page included
        function void clear_state();
            foreach (wram[i])
                wram[i] = 8'h00;
            foreach (hram[i])
            begin
                hram[i]    = 8'h00;
                io_regs[i] = 8'h00;
            end
            io_regs[7'h00] = 8'hCF;
            io_regs[7'h02] = 8'h7E;
            io_regs[7'h07] = 8'hF8;
            io_regs[7'h0F] = 8'hE1;
            io_regs[7'h40] = 8'h91;
            io_regs[7'h41] = 8'h85;
            io_regs[7'h47] = 8'hFC;
            io_regs[7'h48] = 8'hFF;
            io_regs[7'h49] = 8'hFF;
            int_enable = 8'h00;
            bank_sel   = 3'd1;
            color      = 1'b0;
        endfunction

        function void set_color(input logic c);
            color = c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted bus access and update the state
        function void note_access(input logic op, input logic [15:0] addr,
                                  input logic [7:0] data);
            logic [15:0]        a;
            logic [PAGE_AW-1:0] r;
            int                 bank;
            logic [WRAM_AW-1:0] idx;
            result_t            want;
            a    = addr;
            want = '0;
            want.route = ROUTE_INTERNAL;
            // Fold echo space onto work RAM
            if (a >= ADDR_ECHO && a < ADDR_OAM)
                a = a - ECHO_OFFSET;
            if (a < ADDR_VRAM || (a >= ADDR_EXT_RAM && a < ADDR_WRAM))
                want.route = ROUTE_CART;
            else if (a < ADDR_EXT_RAM)
                want.route = ROUTE_VRAM;
            else if (a < ADDR_ECHO)
            begin
                if (a < ADDR_WRAM_BANKED)
                    idx = WRAM_AW'(int'(a - ADDR_WRAM) % BANK_BYTES);
                else
                begin
                    bank = color ? int'(bank_sel) % RAM_BANKS : 1;
                    if (bank == 0)
                        bank = 1;
                    idx = WRAM_AW'(bank * BANK_BYTES
                                   + int'(a - ADDR_WRAM_BANKED) % BANK_BYTES);
                end
                if (op == OP_WRITE)
                    wram[idx] = data;
                else
                    want.read_data = wram[idx];
            end
            else if (a < ADDR_UNUSABLE)
                want.route = ROUTE_OAM;
            else if (a < ADDR_IO)
            begin
                if (op == OP_READ)
                    want.read_data = UNUSABLE_READ;
            end
            else if (a < ADDR_HRAM)
            begin
                r = a[PAGE_AW-1:0];
                if (a == ADDR_VBK && color)
                    want.route = ROUTE_VBANK;
                else if (op == OP_READ)
                begin
                    if (r == IO_IF)
                        want.read_data = IF_READ_SET | io_regs[IO_IF];
                    else if (a == ADDR_SVBK && color)
                        want.read_data = {5'd0, bank_sel};
                    else
                        want.read_data = io_regs[r];
                end
                else if (r == IO_SC)
                begin
                    io_regs[IO_SC] = data;
                    // Transfer start: capture the data byte and flag the interrupt
                    if (data[7])
                    begin
                        want.serial_valid = 1'b1;
                        want.serial_byte  = io_regs[IO_SB];
                        io_regs[IO_SC]    = data & SC_KEEP;
                        io_regs[IO_IF]    = io_regs[IO_IF] | IF_SERIAL;
                    end
                end
                else if (r == IO_IF)
                    io_regs[IO_IF] = data & IF_WRITE_MASK;
                else if (a == ADDR_SVBK && color)
                    bank_sel = data[2:0];
                else
                    io_regs[r] = data;
            end
            else if (a < ADDR_IE)
            begin
                if (op == OP_WRITE)
                    hram[a[PAGE_AW-1:0]] = data;
                else
                    want.read_data = hram[a[PAGE_AW-1:0]];
            end
            else
            begin
                if (op == OP_WRITE)
                    int_enable = data;
                else
                    want.read_data = int_enable;
            end
            if (want.route != ROUTE_INTERNAL)
                want.forward_address = a;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data got %h want %h",
                                          got.read_data, want.read_data));
            if (got.route !== want.route)
                report_mismatch($sformatf("route got %h want %h", got.route, want.route));
            if (got.forward_address !== want.forward_address)
                report_mismatch($sformatf("forward_address got %h want %h",
                                          got.forward_address, want.forward_address));
            if (got.serial_valid !== want.serial_valid)
                report_mismatch($sformatf("serial_valid got %b want %b",
                                          got.serial_valid, want.serial_valid));
            if (got.serial_byte !== want.serial_byte)
                report_mismatch($sformatf("serial_byte got %h want %h",
                                          got.serial_byte, want.serial_byte));
        endtask
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        operation  = 1'b0;
    logic [15:0] address    = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  read_data;
    logic [2:0]  route;
    logic [15:0] forward_address;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_data   = 1'b0;

    bus_scoreboard sb;
    result_t       got_result;
    int            items_sent   = 0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;
    bit            sender_rush  = 1'b0;
    bit            recv_rush    = 1'b0;
    bit            hold_request = 1'b0;

    banked_memory_bus_decoder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .address         (address),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .route           (route),
        .forward_address (forward_address),
        .serial_valid    (serial_valid),
        .serial_byte     (serial_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // Hold reset from the start, then release it for good
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: check each result transfer, then drop ready for a drawn stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_result.read_data       = read_data;
                got_result.route           = route;
                got_result.forward_address = forward_address;
                got_result.serial_valid    = serial_valid;
                got_result.serial_byte     = serial_byte;
                sb.check_result(got_result);
                stall_left = recv_rush ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 49) == 0)
                    recv_rush = !recv_rush;
            end
            if (hold_request)
            begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("banked_memory_bus_decoder_top_tb NOT OK");
            $finish;
        end
    end

    // Offer one access after a drawn gap and hold it until the transfer
    task automatic send_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] data);
        int gap;
        gap = sender_rush ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(op, addr, data);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(input logic c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_color(c);
        cfg_valid <= 1'b0;
    endtask

    // Switch the bank, then touch a few switchable bytes
    task automatic bank_burst();
        send_access(OP_WRITE, ADDR_SVBK, 8'($urandom_range(0, 255)));
        repeat (4)
            send_access(1'($urandom_range(0, 1)),
                        ADDR_WRAM_BANKED + 16'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)));
    endtask

    // Load the serial byte, start the transfer, look at the flags
    task automatic serial_burst();
        logic [7:0] sc;
        sc = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            sc[7] = 1'b1;
        send_access(OP_WRITE, ADDR_IO + IO_SB, 8'($urandom_range(0, 255)));
        send_access(OP_WRITE, ADDR_IO + IO_SC, sc);
        send_access(OP_READ, ADDR_IO + IO_IF, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            send_access(OP_WRITE, ADDR_IO + IO_IF, 8'($urandom_range(0, 255)));
    endtask

    // One access drawn across the map, weighted toward the served regions
    task automatic random_access();
        int          pick;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            a = ADDR_WRAM + 16'($urandom_range(0, 3)) * 16'h1000;
            if ($urandom_range(0, 3) == 0)
                a = a + 16'($urandom_range(0, 4095));
            else
                a = a + 16'($urandom_range(0, 15));
        end
        else if (pick < 45)
        begin
            case ($urandom_range(0, 4))
                0:       a = ADDR_IO + IO_SB;
                1:       a = ADDR_IO + IO_SC;
                2:       a = ADDR_IO + IO_IF;
                3:       a = ADDR_VBK;
                default: a = ADDR_SVBK;
            endcase
        end
        else if (pick < 55)
            a = ADDR_IO + 16'($urandom_range(0, 127));
        else if (pick < 67)
            a = ADDR_HRAM + 16'($urandom_range(0, 127));
        else if (pick < 75)
            a = ADDR_OAM + 16'($urandom_range(0, 255));
        else if (pick < 88)
            a = 16'($urandom_range(0, 16'hBFFF));
        else
            a = 16'($urandom_range(0, 16'hFFFF));
        send_access(1'($urandom_range(0, 1)), a, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 63) == 0)
                sender_rush = !sender_rush;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                bank_burst();
            else if (pick < 16)
                serial_burst();
            else
                random_access();
        end
    endtask

    initial
    begin
        sb = new();
        wait (rst_n);
        @(posedge clk);

        // Older model: region edges, unusable space, flags, serial start
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h7FFF, 8'hFF);
        send_access(OP_READ,  16'h8000, 8'h00);
        send_access(OP_WRITE, 16'h9FFF, 8'h55);
        send_access(OP_WRITE, 16'hBFFF, 8'hAA);
        send_access(OP_WRITE, 16'hC000, 8'hFF);
        send_access(OP_READ,  16'hE000, 8'h00);
        send_access(OP_WRITE, 16'hDFFF, 8'h5A);
        send_access(OP_READ,  16'hFDFF, 8'h00);
        send_access(OP_READ,  16'hFE9F, 8'h00);
        send_access(OP_WRITE, 16'hFEFF, 8'h12);
        send_access(OP_READ,  16'hFEA0, 8'h00);
        send_access(OP_READ,  16'hFF00, 8'h00);
        send_access(OP_READ,  16'hFF0F, 8'h00);
        send_access(OP_WRITE, 16'hFF0F, 8'hFF);
        send_access(OP_WRITE, 16'hFF01, 8'hA5);
        send_access(OP_WRITE, 16'hFF02, 8'h81);
        send_access(OP_READ,  16'hFF02, 8'h00);
        send_access(OP_READ,  16'hFF0F, 8'h00);
        send_access(OP_WRITE, 16'hFF02, 8'h01);
        send_access(OP_WRITE, ADDR_VBK, 8'h3C);
        send_access(OP_READ,  ADDR_VBK, 8'h00);
        send_access(OP_WRITE, ADDR_SVBK, 8'h00);
        send_access(OP_READ,  ADDR_SVBK, 8'h00);
        send_access(OP_WRITE, 16'hFFFE, 8'h80);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF);
        send_access(OP_READ,  16'hFFFF, 8'h00);

        // Colour model: bank zero, top bank, echo into a bank, bank registers
        wait_drained();
        write_color(1'b1);
        send_access(OP_WRITE, ADDR_SVBK, 8'h00);
        send_access(OP_WRITE, 16'hD010, 8'h11);
        send_access(OP_WRITE, ADDR_SVBK, 8'h07);
        send_access(OP_READ,  16'hD010, 8'h00);
        send_access(OP_WRITE, 16'hF010, 8'h77);
        send_access(OP_READ,  16'hD010, 8'h00);
        send_access(OP_WRITE, ADDR_SVBK, 8'hFA);
        send_access(OP_READ,  ADDR_SVBK, 8'h00);
        send_access(OP_WRITE, ADDR_VBK, 8'h01);
        send_access(OP_READ,  ADDR_VBK, 8'h00);

        // Random traffic; open with a long receiver hold to back up the input
        sender_rush  = 1'b1;
        hold_request = 1'b1;
        random_phase(280);
        wait_drained();
        write_color(1'b0);
        random_phase(260);
        wait_drained();
        write_color(1'b1);
        random_phase(260);

        wait_drained();
        if (sb.errors == 0)
            $display("banked_memory_bus_decoder_top_tb OK");
        else
            $display("banked_memory_bus_decoder_top_tb NOT OK");
        $finish;
    end

endmodule
